[hw/rtl/nlc_pkg.sv]
package nlc_pkg;

  localparam int TICK_W   = 31;
  localparam int YEAR_W   = 18;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int STATUS_W = 2;
  localparam int MUL_W    = 32;

  localparam logic [TICK_W-1:0]  EPOCH_HOURS    = 31'd43800000;
  localparam logic [TICK_W-1:0]  TICK_MAX       = 31'h7FFFFFFF;
  localparam int                 DAYS_PER_YEAR  = 365;
  localparam int                 HOURS_PER_DAY  = 24;
  localparam int                 HOURS_PER_YEAR = DAYS_PER_YEAR * HOURS_PER_DAY;
  localparam logic [MONTH_W-1:0] MONTHS         = 4'd12;

  localparam int          YEAR_SHIFT = 45;
  localparam longint      YEAR_RECIP_L =
    ((64'd1 << YEAR_SHIFT) + HOURS_PER_YEAR - 1) / HOURS_PER_YEAR;
  localparam logic [MUL_W-1:0] YEAR_RECIP = YEAR_RECIP_L[MUL_W-1:0];

  localparam int               DIV3_SHIFT = 11;
  localparam logic [MUL_W-1:0] DIV3_RECIP = 32'd683;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EARLY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] idx);
    logic [DAY_W-1:0] d;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
      4'd1:                                     d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:                  d = 5'd30;
      default:                                  d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mo);
    logic [8:0] d;
    unique case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/nlc_mul.sv]
module nlc_mul (
  input  logic                          clk,
  input  logic [nlc_pkg::MUL_W-1:0]     a_i,
  input  logic [nlc_pkg::MUL_W-1:0]     b_i,
  output logic [2*nlc_pkg::MUL_W-1:0]   p_r
);

  logic [2*nlc_pkg::MUL_W-1:0] p_nxt;

  assign p_nxt = a_i * b_i;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

[hw/rtl/noleap_calendar_tick_converter.sv]
// out_valid rises in the cycle after accept for an early count or an invalid date.
// Date to count: S_K1Y, S_K1SUM, S_K1D, S_K1FIN. Count to date: S_YMUL, S_YQ, S_HOY,
// S_D3 and S_D3Q on the shared 32x32 multiplier, then a month walk in S_WALK.
// No new item is taken while busy; start is taken again in the out_valid cycle.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (rst_n low at a clock edge) returns the sequencer to idle and drops out_valid.
module noleap_calendar_tick_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic [nlc_pkg::TICK_W-1:0]       in_tick,
  input  logic [nlc_pkg::YEAR_W-1:0]       in_year,
  input  logic [nlc_pkg::MONTH_W-1:0]      in_month,
  input  logic [nlc_pkg::DAY_W-1:0]        in_day,
  input  logic [nlc_pkg::HOUR_W-1:0]       in_hour,
  output logic                             out_valid,
  output logic [nlc_pkg::TICK_W-1:0]       out_tick_out,
  output logic [nlc_pkg::YEAR_W-1:0]       out_year_out,
  output logic [nlc_pkg::MONTH_W-1:0]      out_month_out,
  output logic [nlc_pkg::DAY_W-1:0]        out_day_out,
  output logic [nlc_pkg::HOUR_W-1:0]       out_hour_out,
  output logic [nlc_pkg::DAY_W-1:0]        out_month_length,
  output logic [nlc_pkg::STATUS_W-1:0]     out_status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_YMUL   = 4'd1;
  localparam logic [3:0] S_YQ     = 4'd2;
  localparam logic [3:0] S_HOY    = 4'd3;
  localparam logic [3:0] S_D3     = 4'd4;
  localparam logic [3:0] S_D3Q    = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_K1Y    = 4'd7;
  localparam logic [3:0] S_K1SUM  = 4'd8;
  localparam logic [3:0] S_K1D    = 4'd9;
  localparam logic [3:0] S_K1FIN  = 4'd10;

  localparam int MW = nlc_pkg::MUL_W;

  logic [3:0]                        state_r, state_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [nlc_pkg::TICK_W-1:0]        tick_r, tick_nxt;
  logic [nlc_pkg::TICK_W-1:0]        hrs_r, hrs_nxt;
  logic [nlc_pkg::YEAR_W-1:0]        year_r, year_nxt;
  logic [13:0]                       hoy_r, hoy_nxt;
  logic [8:0]                        doy_r, doy_nxt;
  logic [nlc_pkg::HOUR_W-1:0]        hour_r, hour_nxt;
  logic [nlc_pkg::MONTH_W-1:0]       m_r, m_nxt;
  logic [nlc_pkg::MONTH_W-1:0]       mo_r, mo_nxt;
  logic [nlc_pkg::DAY_W-1:0]         d_r, d_nxt;
  logic [26:0]                       days_r, days_nxt;

  logic [nlc_pkg::TICK_W-1:0]        o_tick_r, o_tick_nxt;
  logic [nlc_pkg::YEAR_W-1:0]        o_year_r, o_year_nxt;
  logic [nlc_pkg::MONTH_W-1:0]       o_month_r, o_month_nxt;
  logic [nlc_pkg::DAY_W-1:0]         o_day_r, o_day_nxt;
  logic [nlc_pkg::HOUR_W-1:0]        o_hour_r, o_hour_nxt;
  logic [nlc_pkg::DAY_W-1:0]         o_ml_r, o_ml_nxt;
  logic [nlc_pkg::STATUS_W-1:0]      o_st_r, o_st_nxt;

  logic [MW-1:0]                     mul_a, mul_b;
  logic [2*MW-1:0]                   mul_p;

  logic                              accept;
  logic [nlc_pkg::DAY_W-1:0]         walk_md;
  logic [8:0]                        d3_doy;
  logic [13:0]                       doy24;
  logic [13:0]                       hour_diff;
  logic [32:0]                       total;

  nlc_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_r (mul_p)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign walk_md   = nlc_pkg::month_days(m_r);
  assign d3_doy    = mul_p[nlc_pkg::DIV3_SHIFT+8:nlc_pkg::DIV3_SHIFT];
  assign doy24     = {1'b0, d3_doy, 4'b0} + {2'b0, d3_doy, 3'b0};
  assign hour_diff = hoy_r - doy24;
  assign total     = {1'b0, mul_p[MW-1:0]} + {2'b0, nlc_pkg::EPOCH_HOURS}
                   + {28'b0, hour_r};

  always_comb begin
    unique case (state_r)
      S_YMUL: begin
        mul_a = {1'b0, hrs_r};
        mul_b = nlc_pkg::YEAR_RECIP;
      end
      S_YQ: begin
        mul_a = {14'b0, mul_p[nlc_pkg::YEAR_SHIFT+17:nlc_pkg::YEAR_SHIFT]};
        mul_b = MW'(nlc_pkg::HOURS_PER_YEAR);
      end
      S_D3: begin
        mul_a = {21'b0, hoy_r[13:3]};
        mul_b = nlc_pkg::DIV3_RECIP;
      end
      S_K1Y: begin
        mul_a = {14'b0, year_r};
        mul_b = MW'(nlc_pkg::DAYS_PER_YEAR);
      end
      S_K1D: begin
        mul_a = {5'b0, days_r};
        mul_b = MW'(nlc_pkg::HOURS_PER_DAY);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    tick_nxt      = tick_r;
    hrs_nxt       = hrs_r;
    year_nxt      = year_r;
    hoy_nxt       = hoy_r;
    doy_nxt       = doy_r;
    hour_nxt      = hour_r;
    m_nxt         = m_r;
    mo_nxt        = mo_r;
    d_nxt         = d_r;
    days_nxt      = days_r;
    o_tick_nxt    = o_tick_r;
    o_year_nxt    = o_year_r;
    o_month_nxt   = o_month_r;
    o_day_nxt     = o_day_r;
    o_hour_nxt    = o_hour_r;
    o_ml_nxt      = o_ml_r;
    o_st_nxt      = o_st_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            tick_nxt = in_tick;
            hrs_nxt  = in_tick - nlc_pkg::EPOCH_HOURS;
            if (in_tick < nlc_pkg::EPOCH_HOURS) begin
              out_valid_nxt = 1'b1;
              o_tick_nxt    = '0;
              o_year_nxt    = '0;
              o_month_nxt   = '0;
              o_day_nxt     = '0;
              o_hour_nxt    = '0;
              o_ml_nxt      = '0;
              o_st_nxt      = nlc_pkg::ST_EARLY;
            end else begin
              state_nxt = S_YMUL;
            end
          end else begin
            year_nxt = in_year;
            mo_nxt   = in_month;
            d_nxt    = in_day;
            hour_nxt = in_hour;
            if (in_month == '0 || in_month > nlc_pkg::MONTHS || in_day == '0) begin
              out_valid_nxt = 1'b1;
              o_tick_nxt    = '0;
              o_year_nxt    = '0;
              o_month_nxt   = '0;
              o_day_nxt     = '0;
              o_hour_nxt    = '0;
              o_ml_nxt      = '0;
              o_st_nxt      = nlc_pkg::ST_INVALID;
            end else begin
              state_nxt = S_K1Y;
            end
          end
        end
      end
      S_YMUL: begin
        state_nxt = S_YQ;
      end
      S_YQ: begin
        year_nxt  = mul_p[nlc_pkg::YEAR_SHIFT+17:nlc_pkg::YEAR_SHIFT];
        state_nxt = S_HOY;
      end
      S_HOY: begin
        hoy_nxt   = hrs_r[13:0] - mul_p[13:0];
        state_nxt = S_D3;
      end
      S_D3: begin
        state_nxt = S_D3Q;
      end
      S_D3Q: begin
        doy_nxt   = d3_doy;
        hour_nxt  = hour_diff[4:0];
        m_nxt     = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (m_r < 4'd11 && doy_r >= {4'b0, walk_md}) begin
          doy_nxt = doy_r - {4'b0, walk_md};
          m_nxt   = m_r + 4'd1;
        end else begin
          out_valid_nxt = 1'b1;
          o_tick_nxt    = tick_r;
          o_year_nxt    = year_r;
          o_month_nxt   = m_r + 4'd1;
          o_day_nxt     = doy_r[4:0] + 5'd1;
          o_hour_nxt    = hour_r;
          o_ml_nxt      = walk_md;
          o_st_nxt      = nlc_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      S_K1Y: begin
        state_nxt = S_K1SUM;
      end
      S_K1SUM: begin
        days_nxt  = mul_p[26:0] + {18'b0, nlc_pkg::days_before(mo_r)}
                  + {22'b0, d_r} - 27'd1;
        state_nxt = S_K1D;
      end
      S_K1D: begin
        state_nxt = S_K1FIN;
      end
      S_K1FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (total > {2'b0, nlc_pkg::TICK_MAX}) begin
          o_tick_nxt  = '0;
          o_year_nxt  = '0;
          o_month_nxt = '0;
          o_day_nxt   = '0;
          o_hour_nxt  = '0;
          o_ml_nxt    = '0;
          o_st_nxt    = nlc_pkg::ST_OVERFLOW;
        end else begin
          o_tick_nxt  = total[nlc_pkg::TICK_W-1:0];
          o_year_nxt  = year_r;
          o_month_nxt = mo_r;
          o_day_nxt   = d_r;
          o_hour_nxt  = hour_r;
          o_ml_nxt    = nlc_pkg::month_days(mo_r - 4'd1);
          o_st_nxt    = nlc_pkg::ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r    <= tick_nxt;
    hrs_r     <= hrs_nxt;
    year_r    <= year_nxt;
    hoy_r     <= hoy_nxt;
    doy_r     <= doy_nxt;
    hour_r    <= hour_nxt;
    m_r       <= m_nxt;
    mo_r      <= mo_nxt;
    d_r       <= d_nxt;
    days_r    <= days_nxt;
    o_tick_r  <= o_tick_nxt;
    o_year_r  <= o_year_nxt;
    o_month_r <= o_month_nxt;
    o_day_r   <= o_day_nxt;
    o_hour_r  <= o_hour_nxt;
    o_ml_r    <= o_ml_nxt;
    o_st_r    <= o_st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_tick_out     = o_tick_r;
  assign out_year_out     = o_year_r;
  assign out_month_out    = o_month_r;
  assign out_day_out      = o_day_r;
  assign out_hour_out     = o_hour_r;
  assign out_month_length = o_ml_r;
  assign out_status       = o_st_r;

endmodule

[hw/rtl/nlc_checker.sv]
module nlc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             in_kind,
  input  logic [nlc_pkg::TICK_W-1:0]       in_tick,
  input  logic [nlc_pkg::MONTH_W-1:0]      in_month,
  input  logic [nlc_pkg::DAY_W-1:0]        in_day,
  input  logic                             out_valid,
  input  logic [nlc_pkg::TICK_W-1:0]       out_tick_out,
  input  logic [nlc_pkg::MONTH_W-1:0]      out_month_out,
  input  logic [nlc_pkg::DAY_W-1:0]        out_month_length,
  input  logic [nlc_pkg::STATUS_W-1:0]     out_status
);

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && out_valid))
    else $error("result strobe while busy");

  a_early_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_kind && in_tick < nlc_pkg::EPOCH_HOURS)
      |=> (out_valid && out_status == nlc_pkg::ST_EARLY))
    else $error("early count not flagged next cycle");

  a_invalid_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind &&
     (in_month == '0 || in_month > nlc_pkg::MONTHS || in_day == '0))
      |=> (out_valid && out_status == nlc_pkg::ST_INVALID))
    else $error("invalid date not flagged next cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != nlc_pkg::ST_OK)
      |-> (out_tick_out == '0 && out_month_out == '0 && out_month_length == '0))
    else $error("error result carries nonzero fields");

  a_ok_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == nlc_pkg::ST_OK)
      |-> (out_month_out != '0 && out_month_out <= nlc_pkg::MONTHS &&
           out_month_length >= 5'd28))
    else $error("good result with bad month");

endmodule

bind noleap_calendar_tick_converter nlc_checker u_nlc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_kind          (in_kind),
  .in_tick          (in_tick),
  .in_month         (in_month),
  .in_day           (in_day),
  .out_valid        (out_valid),
  .out_tick_out     (out_tick_out),
  .out_month_out    (out_month_out),
  .out_month_length (out_month_length),
  .out_status       (out_status)
);
